/* rtl/scpd_pkg.sv */
// types and constants shared by the stroke corner point decimator, its checker and its bench,
// and the corner test of the decimator
// no dependencies
`timescale 1ns / 1ps

package scpd_pkg;

   localparam int SCALE_WIDTH  = 16;
   localparam int SCALE_FRAC   = 12;
   localparam int THRESH_WIDTH = 12;
   localparam int CSR_IDX_WIDTH = 1;

   localparam logic [SCALE_WIDTH-1:0]  SCALE_RESET  = 16'd4096;
   localparam logic [THRESH_WIDTH-1:0] THRESH_RESET = 12'd10;

   // register indexes of the csr port
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_SCALE_RATIO    = 1'b0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_DIST_THRESHOLD = 1'b1;

   // sign of one axis: -1, 0 or +1
   typedef logic signed [1:0] sgn_type;

   localparam sgn_type SGN_ZERO = 2'sb00;
   localparam sgn_type SGN_POS  = 2'sb01;
   localparam sgn_type SGN_NEG  = 2'sb11;

   // one of eight directions, or none when both axes are zero
   typedef struct packed {
      sgn_type dy;
      sgn_type dx;
   } dir_type;

   localparam dir_type DIR_NONE = '{dy: SGN_ZERO, dx: SGN_ZERO};

   // corner: directions differ and are not neighbours on the ring
   function automatic logic is_corner(input dir_type a, input dir_type b);
      logic signed [2:0] ddx;
      logic signed [2:0] ddy;
      logic        [2:0] adx;
      logic        [2:0] ady;
      logic              neighbour;
      ddx = 3'($signed(a.dx)) - 3'($signed(b.dx));
      ddy = 3'($signed(a.dy)) - 3'($signed(b.dy));
      adx = ddx[2] ? 3'(-ddx) : 3'(ddx);
      ady = ddy[2] ? 3'(-ddy) : 3'(ddy);
      neighbour = ((adx == 3'd1) && (ady == 3'd0)) || ((adx == 3'd0) && (ady == 3'd1));
      if (a == b) begin
         return 1'b0;
      end
      if ((a == DIR_NONE) || (b == DIR_NONE)) begin
         return 1'b1;
      end
      return !neighbour;
   endfunction

endpackage

/* rtl/stroke_corner_point_decimator.sv */
// stroke corner point decimator: keeps the pen points that shape a freehand stroke
// depends on scpd_pkg
// a kept point passes the s1 input register and then the rsp output register
// throughput: one item per cycle unless rsp stalls or a rescale runs; the keep decision
// is combinational on cached scaled history (products and whole parts of stored points)
// a write to scale_ratio holds req_tready low in its cycle and the states PREV, LAST, BEFORE
// and DIR, while the two input multipliers rebuild that cache from the stored raw points
// reset (synchronous, active high) clears the history and loads the register defaults
`timescale 1ns / 1ps

module stroke_corner_point_decimator
   import scpd_pkg::*;
#(
   parameter int COORD_WIDTH = 16,
   parameter int FRAC_BITS   = 4,
   localparam int DATA_WIDTH = ((2 * COORD_WIDTH + 7) / 8) * 8
) (
   input  logic                     clock,
   input  logic                     reset,
   // point_x, point_y, zero fill
   input  logic [DATA_WIDTH-1:0]    req_tdata,
   // stroke_start
   input  logic                     req_tuser,
   // stroke_end
   input  logic                     req_tlast,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // kept_x, kept_y, zero fill
   output logic [DATA_WIDTH-1:0]    rsp_tdata,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   input  logic                     csr_we,
   input  logic [CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [SCALE_WIDTH-1:0]   csr_wdata
);

   localparam int SH   = FRAC_BITS + SCALE_FRAC;
   localparam int PW   = COORD_WIDTH + SCALE_WIDTH;
   localparam int SWW  = PW - SH;
   localparam int MW   = PW + 1;
   localparam int CMPW = (MW > THRESH_WIDTH + SH) ? MW : THRESH_WIDTH + SH;

   typedef enum logic [2:0] {
      RS_IDLE,
      RS_PREV,
      RS_LAST,
      RS_BEFORE,
      RS_DIR
   } rescale_type;

   // whole part of a scaled value, truncated toward zero
   function automatic logic signed [SWW-1:0] whole_of(input logic signed [PW-1:0] p);
      logic corr;
      corr = p[PW-1] & (|p[SH-1:0]);
      return $signed(p[PW-1:SH] + SWW'(corr));
   endfunction

   function automatic sgn_type sign_of(input logic signed [SWW-1:0] a,
                                       input logic signed [SWW-1:0] b);
      logic signed [SWW:0] d;
      d = (SWW+1)'(a) - (SWW+1)'(b);
      if (d == '0) begin
         return SGN_ZERO;
      end
      return d[SWW] ? SGN_NEG : SGN_POS;
   endfunction

   function automatic logic far_of(input logic signed [PW-1:0] p,
                                   input logic signed [PW-1:0] q,
                                   input logic [THRESH_WIDTH-1:0] thr);
      logic signed [MW-1:0] d;
      logic        [MW-1:0] mag;
      d   = MW'(p) - MW'(q);
      mag = d[MW-1] ? MW'(-d) : MW'(d);
      return CMPW'(mag) >= (CMPW'(thr) << SH);
   endfunction

   logic [SCALE_WIDTH-1:0]  scale_ff;
   logic [THRESH_WIDTH-1:0] thresh_ff;
   rescale_type             rs_ff;
   rescale_type             rs_in;

   logic                          s1_valid_ff;
   logic signed [COORD_WIDTH-1:0] s1_x_ff, s1_y_ff;
   logic                          s1_start_ff, s1_end_ff;
   logic signed [PW-1:0]          s1_px_ff, s1_py_ff;

   logic [1:0]                    raw_count_ff;
   logic [1:0]                    raw_count_in;
   logic signed [COORD_WIDTH-1:0] prev_x_ff, prev_y_ff;
   logic signed [COORD_WIDTH-1:0] last_x_ff, last_y_ff;
   logic signed [COORD_WIDTH-1:0] before_x_ff, before_y_ff;
   logic signed [SWW-1:0]         sw_prev_x_ff, sw_prev_y_ff;
   logic signed [SWW-1:0]         sw_last_x_ff, sw_last_y_ff;
   logic signed [PW-1:0]          p_last_x_ff, p_last_y_ff;
   dir_type                       kdir_ff;

   logic                          rsp_valid_ff;
   logic signed [COORD_WIDTH-1:0] rsp_x_ff, rsp_y_ff;

   logic                          scale_wr;
   logic                          out_free;
   logic                          process;
   logic                          accept;
   logic signed [COORD_WIDTH-1:0] mul_x_op, mul_y_op;
   logic signed [SCALE_WIDTH:0]   scale_s;
   logic signed [PW-1:0]          prod_x, prod_y;
   logic signed [SWW-1:0]         sw_x, sw_y;
   dir_type                       raw_dir;
   dir_type                       kdir_in;
   dir_type                       sweep_dir;
   logic                          keep;

   assign scale_wr   = csr_we && (csr_index == CSR_SCALE_RATIO);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign process    = s1_valid_ff && out_free;
   assign req_tready = (rs_ff == RS_IDLE) && !scale_wr && (!s1_valid_ff || out_free);
   assign accept     = req_tvalid && req_tready;

   // input multipliers, shared with the rescale sweep
   always_comb begin
      unique case (rs_ff)
         RS_PREV: begin
            mul_x_op = prev_x_ff;
            mul_y_op = prev_y_ff;
         end
         RS_LAST: begin
            mul_x_op = last_x_ff;
            mul_y_op = last_y_ff;
         end
         RS_BEFORE: begin
            mul_x_op = before_x_ff;
            mul_y_op = before_y_ff;
         end
         default: begin
            mul_x_op = $signed(req_tdata[COORD_WIDTH-1:0]);
            mul_y_op = $signed(req_tdata[2*COORD_WIDTH-1:COORD_WIDTH]);
         end
      endcase
   end

   assign scale_s = $signed({1'b0, scale_ff});
   assign prod_x  = PW'(mul_x_op) * PW'(scale_s);
   assign prod_y  = PW'(mul_y_op) * PW'(scale_s);

   // keep decision on the registered item
   assign sw_x = whole_of(s1_px_ff);
   assign sw_y = whole_of(s1_py_ff);

   assign raw_dir.dx   = sign_of(sw_x, sw_prev_x_ff);
   assign raw_dir.dy   = sign_of(sw_y, sw_prev_y_ff);
   assign kdir_in.dx   = sign_of(sw_x, sw_last_x_ff);
   assign kdir_in.dy   = sign_of(sw_y, sw_last_y_ff);
   assign sweep_dir.dx = sign_of(sw_last_x_ff, sw_x);
   assign sweep_dir.dy = sign_of(sw_last_y_ff, sw_y);

   always_comb begin
      if (s1_start_ff) begin
         raw_count_in = 2'd1;
      end else if (raw_count_ff != 2'd3) begin
         raw_count_in = raw_count_ff + 2'd1;
      end else begin
         raw_count_in = raw_count_ff;
      end
      keep = (raw_count_in != 2'd3) || s1_end_ff
             || far_of(s1_px_ff, p_last_x_ff, thresh_ff)
             || far_of(s1_py_ff, p_last_y_ff, thresh_ff)
             || is_corner(raw_dir, kdir_ff);
   end

   always_comb begin
      if (scale_wr) begin
         rs_in = RS_PREV;
      end else begin
         unique case (rs_ff)
            RS_PREV:   rs_in = RS_LAST;
            RS_LAST:   rs_in = RS_BEFORE;
            RS_BEFORE: rs_in = RS_DIR;
            default:   rs_in = RS_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff     <= SCALE_RESET;
         thresh_ff    <= THRESH_RESET;
         rs_ff        <= RS_IDLE;
         s1_valid_ff  <= 1'b0;
         raw_count_ff <= '0;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         last_x_ff    <= '0;
         last_y_ff    <= '0;
         before_x_ff  <= '0;
         before_y_ff  <= '0;
         sw_prev_x_ff <= '0;
         sw_prev_y_ff <= '0;
         sw_last_x_ff <= '0;
         sw_last_y_ff <= '0;
         p_last_x_ff  <= '0;
         p_last_y_ff  <= '0;
         kdir_ff      <= DIR_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_SCALE_RATIO:    scale_ff  <= csr_wdata;
               CSR_DIST_THRESHOLD: thresh_ff <= csr_wdata[THRESH_WIDTH-1:0];
               default: ;
            endcase
         end
         rs_ff <= rs_in;

         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (process) begin
            s1_valid_ff <= 1'b0;
         end

         if (out_free) begin
            rsp_valid_ff <= process && keep;
         end

         if (process) begin
            raw_count_ff <= raw_count_in;
            prev_x_ff    <= s1_x_ff;
            prev_y_ff    <= s1_y_ff;
            sw_prev_x_ff <= sw_x;
            sw_prev_y_ff <= sw_y;
            if (keep) begin
               before_x_ff  <= last_x_ff;
               before_y_ff  <= last_y_ff;
               last_x_ff    <= s1_x_ff;
               last_y_ff    <= s1_y_ff;
               sw_last_x_ff <= sw_x;
               sw_last_y_ff <= sw_y;
               p_last_x_ff  <= s1_px_ff;
               p_last_y_ff  <= s1_py_ff;
               kdir_ff      <= kdir_in;
            end
         end else begin
            // rebuild the cached scaled history one stored point a cycle
            unique case (rs_ff)
               RS_LAST: begin
                  sw_prev_x_ff <= sw_x;
                  sw_prev_y_ff <= sw_y;
               end
               RS_BEFORE: begin
                  sw_last_x_ff <= sw_x;
                  sw_last_y_ff <= sw_y;
                  p_last_x_ff  <= s1_px_ff;
                  p_last_y_ff  <= s1_py_ff;
               end
               RS_DIR: begin
                  kdir_ff <= sweep_dir;
               end
               default: ;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept || (rs_ff != RS_IDLE)) begin
         s1_px_ff <= prod_x;
         s1_py_ff <= prod_y;
      end
      if (accept) begin
         s1_x_ff     <= mul_x_op;
         s1_y_ff     <= mul_y_op;
         s1_start_ff <= req_tuser;
         s1_end_ff   <= req_tlast;
      end
      if (process && keep) begin
         rsp_x_ff <= s1_x_ff;
         rsp_y_ff <= s1_y_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DATA_WIDTH'({rsp_y_ff, rsp_x_ff});

endmodule

/* rtl/scpd_checker.sv */
// port-level checks for the stroke corner point decimator, bound to the top level
// depends on scpd_pkg and stroke_corner_point_decimator
`timescale 1ns / 1ps

module scpd_checker
   import scpd_pkg::*;
#(
   parameter int COORD_WIDTH = 16,
   localparam int DATA_WIDTH = ((2 * COORD_WIDTH + 7) / 8) * 8
) (
   input logic                     clock,
   input logic                     reset,
   input logic [DATA_WIDTH-1:0]    req_tdata,
   input logic                     req_tuser,
   input logic                     req_tlast,
   input logic                     req_tvalid,
   input logic                     req_tready,
   input logic [DATA_WIDTH-1:0]    rsp_tdata,
   input logic                     rsp_tvalid,
   input logic                     rsp_tready,
   input logic                     csr_we,
   input logic [CSR_IDX_WIDTH-1:0] csr_index
);

   localparam int PW = 2 * COORD_WIDTH;

   // a stalled result holds
   rsp_hold_a: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp item changed while stalled");

   // no output left over from before reset
   rsp_reset_a: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid right after reset");

   // a stroke start or stroke end point is always passed on, unchanged
   mark_kept_a: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser || req_tlast))
         ##1 (!rsp_tvalid || rsp_tready)
      |=> rsp_tvalid && (rsp_tdata[PW-1:0] == $past(req_tdata[PW-1:0], 2)))
      else $error("marked item not passed on");

   // the scaled history is rebuilt after a scale write, no item taken meanwhile
   rescale_block_a: assert property (@(posedge clock) disable iff (reset)
      csr_we && (csr_index == CSR_SCALE_RATIO) |=> !req_tready)
      else $error("item taken while scaled history is rebuilt");

endmodule

bind stroke_corner_point_decimator scpd_checker #(.COORD_WIDTH(COORD_WIDTH)) u_scpd_checker (.*);

/* sim/stroke_corner_point_decimator_tb.sv */
// self-checking bench for the stroke corner point decimator: directed table, then random strokes
// under several scale and threshold settings, with random stalls on both stream sides
// depends on scpd_pkg and rtl/stroke_corner_point_decimator.sv
`timescale 1ns / 1ps

module stroke_corner_point_decimator_tb;
   import scpd_pkg::*;

   localparam int COORD_W     = 16;
   localparam int FRAC_B      = 4;
   localparam int TDATA_W     = 32;
   localparam int WHOLE_SHIFT = FRAC_B + SCALE_FRAC;
   localparam int RANDOM_PER_SETTING = 220;
   localparam int SETTLE_CYCLES = 8;
   localparam longint CYCLE_LIMIT = 1000000;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic                      start_mark;
      logic                      end_mark;
   } pen_point_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
   } kept_point_type;

   typedef struct {
      pen_point_type pt;
      bit            always_kept;
   } directed_row_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic [TDATA_W-1:0]       req_tdata = '0;
   logic                     req_tuser = 1'b0;
   logic                     req_tlast = 1'b0;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [TDATA_W-1:0]       rsp_tdata;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic                     csr_we = 1'b0;
   logic [CSR_IDX_WIDTH-1:0] csr_index = '0;
   logic [SCALE_WIDTH-1:0]   csr_wdata = '0;

   stroke_corner_point_decimator #(
      .COORD_WIDTH(COORD_W),
      .FRAC_BITS  (FRAC_B)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .req_tlast (req_tlast),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // predictor state: stroke history and register copies
   logic [SCALE_WIDTH-1:0]  cfg_scale = SCALE_RESET;
   logic [THRESH_WIDTH-1:0] cfg_thresh = THRESH_RESET;
   int     stroke_count = 0;
   longint prev_x = 0, prev_y = 0;
   longint anchor_x = 0, anchor_y = 0;
   longint trail_x = 0, trail_y = 0;

   kept_point_type   pending_kept[$];
   directed_row_type directed_rows[$];
   int     errors = 0;
   int     points_sent = 0;
   int     kept_seen = 0;
   int     settings_run = 0;
   bit     steady = 1'b0;
   int     stall_left = 0;
   longint cycles = 0;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   function automatic int rand_signed(int reach);
      return int'($urandom_range(0, 2 * reach)) - reach;
   endfunction

   // whole part of c * scale, truncated toward zero
   function automatic longint whole_part(longint c);
      longint p;
      p = c * longint'(cfg_scale);
      if (p < 0) return -((-p) >>> WHOLE_SHIFT);
      return p >>> WHOLE_SHIFT;
   endfunction

   function automatic bit beyond_threshold(longint a, longint b);
      longint p;
      p = (a - b) * longint'(cfg_scale);
      if (p < 0) p = -p;
      return p >= (longint'(cfg_thresh) <<< WHOLE_SHIFT);
   endfunction

   function automatic int sign3(longint v);
      return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
   endfunction

   // two headings on the 8-way ring that are neither equal nor adjacent, or only one is none
   function automatic bit sharp_turn(int ax, int ay, int bx, int by);
      int ddx, ddy;
      if (ax == bx && ay == by) return 1'b0;
      if ((ax == 0 && ay == 0) || (bx == 0 && by == 0)) return 1'b1;
      ddx = (ax > bx) ? ax - bx : bx - ax;
      ddy = (ay > by) ? ay - by : by - ay;
      return !((ddx == 1 && ddy == 0) || (ddx == 0 && ddy == 1));
   endfunction

   function automatic bit decide_keep(pen_point_type p);
      longint x, y;
      bit     keep;
      x = longint'(p.x);
      y = longint'(p.y);
      if (p.start_mark) stroke_count = 1;
      else if (stroke_count < 3) stroke_count++;
      if (stroke_count <= 2 || p.end_mark) begin
         keep = 1'b1;
      end else if (beyond_threshold(x, anchor_x) || beyond_threshold(y, anchor_y)) begin
         keep = 1'b1;
      end else begin
         keep = sharp_turn(sign3(whole_part(x) - whole_part(prev_x)),
                           sign3(whole_part(y) - whole_part(prev_y)),
                           sign3(whole_part(anchor_x) - whole_part(trail_x)),
                           sign3(whole_part(anchor_y) - whole_part(trail_y)));
      end
      prev_x = x;
      prev_y = y;
      if (keep) begin
         trail_x  = anchor_x;
         trail_y  = anchor_y;
         anchor_x = x;
         anchor_y = y;
      end
      return keep;
   endfunction

   // offers one item and, once taken, works out whether it should come back
   task automatic send_point(input pen_point_type p, input bit always_kept);
      int             gap;
      bit             keep;
      kept_point_type k;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {p.y, p.x};
      req_tuser  <= p.start_mark;
      req_tlast  <= p.end_mark;
      do @(posedge clock); while (req_tready !== 1'b1);
      points_sent++;
      keep = decide_keep(p);
      k.x = p.x;
      k.y = p.y;
      if (always_kept || keep) pending_kept.insert(pending_kept.size(), k);
   endtask

   // lets the block go idle; dropped items may still be in flight after the last result
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_kept.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_WIDTH-1:0] idx,
                            input logic [SCALE_WIDTH-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      if (idx == CSR_SCALE_RATIO) cfg_scale = value;
      else cfg_thresh = value[THRESH_WIDTH-1:0];
   endtask

   task automatic add_row(input int x, input int y, input bit s, input bit e, input bit sure);
      directed_row_type row;
      row.pt.x          = x[COORD_W-1:0];
      row.pt.y          = y[COORD_W-1:0];
      row.pt.start_mark = s;
      row.pt.end_mark   = e;
      row.always_kept   = sure;
      directed_rows.insert(directed_rows.size(), row);
   endtask

   task automatic send_noise();
      pen_point_type p;
      logic [31:0]   rnd;
      rnd          = $urandom;
      p.x          = rnd[15:0];
      p.y          = rnd[31:16];
      p.start_mark = ($urandom_range(0, 3) == 0);
      p.end_mark   = ($urandom_range(0, 3) == 0);
      send_point(p, 1'b0);
   endtask

   // a pen stroke: start mark, a heading with jitter and occasional turns, usually an end mark
   task automatic run_stroke();
      int            len, reach, r, hx, hy, cx, cy, i;
      pen_point_type p;
      len   = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 30);
      r     = $urandom_range(0, 99);
      reach = (r < 50) ? 24 : (r < 80) ? 200 : (r < 95) ? 2000 : 40000;
      cx    = $urandom_range(0, 65535);
      cy    = $urandom_range(0, 65535);
      hx    = rand_signed(reach);
      hy    = rand_signed(reach);
      for (i = 0; i < len; i++) begin
         if (i > 0 && $urandom_range(0, 4) == 0) begin
            hx = rand_signed(reach);
            hy = rand_signed(reach);
         end
         cx = cx + hx + rand_signed(reach / 8);
         cy = cy + hy + rand_signed(reach / 8);
         p.x          = cx[COORD_W-1:0];
         p.y          = cy[COORD_W-1:0];
         p.start_mark = (i == 0) || ($urandom_range(0, 49) == 0);
         p.end_mark   = (i == len - 1) ? ($urandom_range(0, 4) != 0)
                                       : ($urandom_range(0, 29) == 0);
         send_point(p, 1'b0);
      end
   endtask

   // result side backpressure
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 7) == 0) stall_left <= pick_gap();
      end
   end

   always @(posedge clock) begin
      kept_point_type want;
      logic signed [COORD_W-1:0] got_x, got_y;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_x = rsp_tdata[COORD_W-1:0];
         got_y = rsp_tdata[2*COORD_W-1:COORD_W];
         kept_seen++;
         if (pending_kept.size() == 0) begin
            $display("%0t: unexpected kept item x=%0d y=%0d", $time, got_x, got_y);
            errors++;
         end else begin
            want = pending_kept.pop_front();
            if (got_x !== want.x) begin
               $display("%0t: kept_x expected %0d got %0d", $time, want.x, got_x);
               errors++;
            end
            if (got_y !== want.y) begin
               $display("%0t: kept_y expected %0d got %0d", $time, want.y, got_y);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("%0t: timed out with %0d kept items outstanding", $time, pending_kept.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   logic [SCALE_WIDTH-1:0]  scale_plan[8]  = '{16'hFFFF, 16'd0, 16'd0, 16'hFFFF,
                                               16'd4096, 16'd2048, 16'd0, 16'd0};
   logic [THRESH_WIDTH-1:0] thresh_plan[8] = '{12'd0, 12'hFFF, 12'd0, 12'hFFF,
                                               12'd10, 12'd1, 12'd0, 12'd0};

   initial begin
      int k, phase_base;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part under the reset register values (scale 1.0, threshold 10)
      add_row( 32767, -32768, 0, 0, 1);  // no start mark after reset
      add_row(-32768,  32767, 0, 0, 1);
      add_row(-32768,  32767, 0, 0, 0);  // no movement against a real heading
      add_row(   100,    200, 1, 1, 1);  // start and end on one point
      add_row(   116,    200, 0, 0, 1);
      add_row(   132,    200, 0, 0, 0);  // same heading
      add_row(   148,    216, 0, 0, 0);  // neighbouring heading
      add_row(   148,    232, 0, 0, 0);  // right-angle turn
      add_row(   132,    232, 0, 0, 0);
      add_row(   400,    232, 0, 0, 0);  // beyond threshold
      add_row(   400,    232, 0, 1, 1);
      add_row(   416,    232, 0, 0, 0);  // stroke goes on after the end mark
      add_row(   432,    200, 0, 0, 0);
      add_row(-32768, -32768, 1, 0, 1);
      add_row( 32767,  32767, 0, 1, 1);
      add_row(     0,      0, 1, 0, 1);
      add_row(   -16,      0, 0, 0, 1);
      add_row(   -32,      0, 0, 0, 0);
      add_row(   -32,    -16, 0, 0, 0);
      add_row(   -48,     16, 0, 0, 0);
      add_row(   -32,    -16, 0, 1, 1);
      foreach (directed_rows[i]) send_point(directed_rows[i].pt, directed_rows[i].always_kept);

      for (k = 0; k < 8; k++) begin
         settle();
         if (k >= 6) begin
            scale_plan[k]  = SCALE_WIDTH'($urandom_range(0, 65535));
            thresh_plan[k] = THRESH_WIDTH'($urandom_range(0, 40));
         end
         write_csr(CSR_SCALE_RATIO, scale_plan[k]);
         write_csr(CSR_DIST_THRESHOLD, {{(SCALE_WIDTH-THRESH_WIDTH){1'b0}}, thresh_plan[k]});
         csr_we <= 1'b0;
         steady = (k == 2 || k == 5);
         settings_run++;
         phase_base = points_sent;
         while (points_sent - phase_base < RANDOM_PER_SETTING) begin
            if ($urandom_range(0, 6) == 0) send_noise();
            else run_stroke();
         end
      end

      settle();
      $display("sent %0d pen items across %0d register settings plus the reset values",
               points_sent, settings_run);
      $display("checked %0d kept items, %0d mismatches", kept_seen, errors);
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

/* stroke_corner_point_decimator.f */
rtl/scpd_pkg.sv
rtl/stroke_corner_point_decimator.sv
rtl/scpd_checker.sv
sim/stroke_corner_point_decimator_tb.sv
